### src/esfp_pkg.sv
// Shared constants and types for the e-bike status frame parser.
// No dependencies; imported by ebike_status_frame_parser.
package esfp_pkg;

   localparam int FRAME_BYTES = 12;
   localparam int POS_W       = $clog2(FRAME_BYTES);

   localparam logic [7:0] HEADER_BYTE = 8'h41;

   // byte positions inside a frame
   localparam logic [POS_W-1:0] PERIOD_HI_INDEX = POS_W'(3);
   localparam logic [POS_W-1:0] PERIOD_LO_INDEX = POS_W'(4);
   localparam logic [POS_W-1:0] CHECK_INDEX     = POS_W'(6);
   localparam logic [POS_W-1:0] BRAKE_INDEX     = POS_W'(7);
   localparam logic [POS_W-1:0] POWER_INDEX     = POS_W'(8);
   localparam logic [POS_W-1:0] TEMP_INDEX      = POS_W'(9);
   localparam logic [POS_W-1:0] LAST_INDEX      = POS_W'(FRAME_BYTES - 1);

   localparam int BRAKE_BIT = 5;

   // serial divide and multiply work on 16-bit operands, one bit per cycle
   localparam int SER_W = 16;
   localparam int CNT_W = $clog2(SER_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SER_W - 1);

   localparam logic [SER_W-1:0] RPM_DIVIDEND = SER_W'(60000);
   localparam logic [2*SER_W:0] ROUND_HALF   = (2*SER_W+1)'(128);
   localparam int MIN_SPEED = 2;
   localparam int MAX_SPEED = 255;
   localparam logic [8:0] TEMP_OFFSET = 9'd15;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_COLLECT,
      ST_DIVIDE,
      ST_MULT,
      ST_DONE
   } state_type;

endpackage

### src/ebike_status_frame_parser.sv
// Status frame parser for a motor controller serial link.
// Depends on esfp_pkg for frame layout, constants and the state type.
//
// Feed received serial bytes on req_; bytes are dropped until the header 0x41, then
// a frame of FRAME_BYTES bytes is collected, one byte per transfer. A frame whose XOR
// check byte matches yields one result on rsp_: speed, power and temperature in
// rsp_tdata, brake flag in rsp_tuser. Bytes are taken at one per cycle while a frame
// is collected. After the last byte of a good frame the speed is computed by a
// bit-serial divider and then a bit-serial shift-add multiplier, after which it is
// rounded and loaded into the output register; req_tready stays low throughout, and
// longer if the previous result has not yet been taken. A bad frame returns straight
// to hunting for a header. csr_wr_data sets the Q8.8 speed scale (reset 256).
module ebike_status_frame_parser
   import esfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] speed_kmh, [19:8] power_watts,
                                    // [28:20] motor_temperature, [31:29] zero
   output logic        rsp_tuser,   // [0] brake_active
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [15:0]      scale_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       per_hi_ff, per_hi_in;
   logic [7:0]       per_lo_ff, per_lo_in;
   logic [7:0]       chk_ff, chk_in;
   logic             brake_ff, brake_in;
   logic [7:0]       power_byte_ff, power_byte_in;
   logic [7:0]       temp_byte_ff, temp_byte_in;
   logic [SER_W-1:0] rem_ff, rem_in;
   logic [SER_W-1:0] quo_ff, quo_in;
   logic [2*SER_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       speed_ff, speed_in;
   logic [11:0]      power_ff, power_in;
   logic [8:0]       temp_ff, temp_in;
   logic             brake_out_ff, brake_out_in;

   logic req_fire;
   logic out_free;
   logic out_load;
   logic is_header;
   logic frame_end;
   logic check_ok;

   logic [SER_W-1:0] period;
   logic [SER_W:0]   rem_shift;
   logic             quo_bit;
   logic [SER_W:0]   mult_sum;
   logic [2*SER_W:0] rounded;
   logic [2*SER_W-8:0] speed_raw;
   logic [11:0]      power_ext;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_header = req_tdata == HEADER_BYTE;
   assign frame_end = req_fire && (pos_ff == LAST_INDEX);
   assign check_ok  = xor_in == chk_ff;

   assign period    = {per_hi_ff, per_lo_ff};
   assign rem_shift = {rem_ff, quo_ff[SER_W-1]};
   assign quo_bit   = rem_shift >= {1'b0, period};
   assign mult_sum  = {1'b0, prod_ff[2*SER_W-1:SER_W]} +
                      (prod_ff[0] ? {1'b0, scale_ff} : {(SER_W+1){1'b0}});
   assign rounded   = {1'b0, prod_ff} + ROUND_HALF;
   assign speed_raw = rounded[2*SER_W:8];
   assign power_ext = {4'b0, power_byte_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT: begin
            if (req_fire && is_header) state_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            if (frame_end) state_in = check_ok ? ST_DIVIDE : ST_HUNT;
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_LAST) state_in = ST_MULT;
         end
         ST_MULT: begin
            if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_HUNT;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_HUNT, ST_COLLECT: req_tready = 1'b1;
         ST_DONE:             out_load   = out_free;
         default: begin
            req_tready = 1'b0;
            out_load   = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      per_hi_in     = per_hi_ff;
      per_lo_in     = per_lo_ff;
      chk_in        = chk_ff;
      brake_in      = brake_ff;
      power_byte_in = power_byte_ff;
      temp_byte_in  = temp_byte_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      prod_in       = prod_ff;
      cnt_in        = cnt_ff;
      speed_in      = speed_ff;
      power_in      = power_ff;
      temp_in       = temp_ff;
      brake_out_in  = brake_out_ff;

      if (state_ff == ST_HUNT && req_fire && is_header) begin
         pos_in = POS_W'(1);
         xor_in = 8'h00;
      end

      if (state_ff == ST_COLLECT && req_fire) begin
         if (pos_ff != CHECK_INDEX) xor_in = xor_ff ^ req_tdata;
         if (pos_ff == PERIOD_HI_INDEX) per_hi_in = req_tdata;
         if (pos_ff == PERIOD_LO_INDEX) per_lo_in = req_tdata;
         if (pos_ff == CHECK_INDEX) chk_in = req_tdata;
         if (pos_ff == BRAKE_INDEX) brake_in = req_tdata[BRAKE_BIT];
         if (pos_ff == POWER_INDEX) power_byte_in = req_tdata;
         if (pos_ff == TEMP_INDEX) temp_byte_in = req_tdata;
         if (frame_end) begin
            pos_in = '0;
            rem_in = '0;
            quo_in = RPM_DIVIDEND;
            cnt_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      // restoring divide, one quotient bit per cycle
      if (state_ff == ST_DIVIDE) begin
         rem_in = quo_bit ? SER_W'(rem_shift - {1'b0, period}) : rem_shift[SER_W-1:0];
         quo_in = {quo_ff[SER_W-2:0], quo_bit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) prod_in = {{SER_W{1'b0}}, quo_ff[SER_W-2:0], quo_bit};
      end

      // shift-add multiply by the scale, LSB of quotient first
      if (state_ff == ST_MULT) begin
         prod_in = {mult_sum, prod_ff[SER_W-1:1]};
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      if (out_load) begin
         if (period == '0 || speed_raw < (2*SER_W-7)'(MIN_SPEED)) begin
            speed_in = 8'd0;
         end else if (speed_raw > (2*SER_W-7)'(MAX_SPEED)) begin
            speed_in = 8'd255;
         end else begin
            speed_in = speed_raw[7:0];
         end
         power_in     = (power_ext << 3) + (power_ext << 2) + power_ext;
         temp_in      = {temp_byte_ff[7], temp_byte_ff} + TEMP_OFFSET;
         brake_out_in = brake_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         pos_ff       <= '0;
         xor_ff       <= 8'h00;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= SCALE_RESET;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) scale_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      per_hi_ff     <= per_hi_in;
      per_lo_ff     <= per_lo_in;
      chk_ff        <= chk_in;
      brake_ff      <= brake_in;
      power_byte_ff <= power_byte_in;
      temp_byte_ff  <= temp_byte_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      prod_ff       <= prod_in;
      speed_ff      <= speed_in;
      power_ff      <= power_in;
      temp_ff       <= temp_in;
      brake_out_ff  <= brake_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, temp_ff, power_ff, speed_ff};
   assign rsp_tuser  = brake_out_ff;

   a_no_input_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_MULT || state_ff == ST_DONE) |-> !req_tready)
      else $error("byte taken while computing speed");

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT) |-> (pos_ff != '0 && pos_ff <= LAST_INDEX))
      else $error("frame position out of range while collecting");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside of the finishing state");

   a_mult_follows_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && cnt_ff == CNT_LAST) |=> (state_ff == ST_MULT && cnt_ff == '0))
      else $error("multiply did not start cleanly after divide");

endmodule
